>>> sv/smrb_pkg.sv
// Package for the session message retention buffer.
// Holds the transaction structs, function and status codes, and default sizes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package smrb_pkg;

  localparam int SESSIONS_DEF = 16;
  localparam int SLOTS_DEF    = 64;

  localparam logic [1:0] FUNC_STORE = 2'd0;
  localparam logic [1:0] FUNC_ACK   = 2'd1;
  localparam logic [1:0] FUNC_PRUNE = 2'd2;
  localparam logic [1:0] FUNC_LIST  = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_DUP       = 3'd1;
  localparam logic [2:0] ST_INVALID   = 3'd2;
  localparam logic [2:0] ST_NO_SESS   = 3'd3;
  localparam logic [2:0] ST_NO_SLOT   = 3'd4;

  localparam logic REG_MAX_PENDING = 1'b0;
  localparam logic REG_TTL_MS      = 1'b1;

  localparam logic [6:0] LIST_CAP_MAX  = 7'd64;
  localparam logic [6:0] PENDING_MAX   = 7'd64;
  localparam logic [6:0] PENDING_RST   = 7'd64;
  localparam logic [31:0] TTL_RST      = 32'd30000;
  localparam logic [10:0] REMOVED_SAT  = 11'h7FF;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] owner_id;
    logic [31:0] msg_seq;
    logic [31:0] payload_handle;
    logic [39:0] now_ms;
    logic [6:0]  list_capacity;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [10:0] freed_count;
    logic        has_message;
    logic [31:0] out_seq;
    logic [31:0] out_payload;
    logic        last;
  } rsp_t;

  typedef struct packed {
    logic [31:0] seq;
    logic [31:0] payload;
    logic [39:0] written;
    logic [40:0] expiry;
  } rec_t;

endpackage
`default_nettype wire

>>> sv/smrb_ram.sv
// Generic simple dual-port RAM, one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module smrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> sv/session_message_retention_buffer_core.sv
// Top level of the session message retention buffer: session table, sequencer, output register.
// Depends on smrb_pkg and smrb_ram.
//
//  channel | signals                           | direction
//  req     | req_valid, req_stall, req         | in, accepted on valid & !stall
//  rsp     | rsp_valid, rsp_stall, rsp         | out, taken on valid & !stall
//  cfg     | cfg_write, cfg_index, cfg_data    | in, written when cfg_write
//
// One transaction at a time; the store and compaction scans read the record RAM one slot per cycle.
// Store: row search, then a scan of the row's records, then the write. Ack: row search, then compaction.
// Prune: steps through every row and compacts each used row. List: reads one slot at a time.
// Each transaction ends by loading its final result.
// Reset clears session flags and loads register defaults; slots below the row count are valid.
// rsp_stall holds the sequencer before each result is loaded.
`timescale 1ns / 1ps
`default_nettype none
module session_message_retention_buffer_core #(
  parameter int SESSIONS = smrb_pkg::SESSIONS_DEF,
  parameter int SLOTS    = smrb_pkg::SLOTS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire smrb_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output smrb_pkg::rsp_t     rsp,
  input  wire logic          cfg_write,
  input  wire logic          cfg_index,
  input  wire logic [31:0]   cfg_data
);
  import smrb_pkg::*;

  localparam int ROW_W  = SESSIONS > 1 ? $clog2(SESSIONS) : 1;
  localparam int SLOT_W = SLOTS > 1 ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int DEPTH  = SESSIONS * SLOTS;
  localparam int ADDR_W = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(SESSIONS - 1);
  localparam logic [CNT_W-1:0] SLOTS_C  = CNT_W'(SLOTS);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_SCAN    = 4'd1;
  localparam logic [3:0] S_STSCAN  = 4'd2;
  localparam logic [3:0] S_STWR    = 4'd3;
  localparam logic [3:0] S_COMPACT = 4'd4;
  localparam logic [3:0] S_PRROW   = 4'd5;
  localparam logic [3:0] S_LIST    = 4'd6;
  localparam logic [3:0] S_DONE    = 4'd7;

  logic [3:0]  state;
  req_t        op;
  logic [6:0]  max_pending;
  logic [31:0] ttl_ms;

  logic [SESSIONS-1:0] sess_used;
  logic [31:0]         sess_owner [SESSIONS];
  logic [CNT_W-1:0]    sess_count [SESSIONS];

  logic [ROW_W-1:0]  idx, free_row;
  logic              free_ok;
  logic [CNT_W-1:0]  cur_cnt, s, n, k;
  logic              pend, dup, have_best;
  logic [SLOT_W-1:0] best_slot;
  logic [39:0]       best_w;
  logic [10:0]       removed;
  logic [6:0]        cap;
  logic              held_valid;
  logic [31:0]       held_seq, held_pay;
  rsp_t              res;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  rec_t              mem_wdata, rd;
  logic              drop, out_free, append, match, qual;
  logic [SLOT_W-1:0] wslot;
  rsp_t              empty_rsp, msg_rsp, last_rsp;
  logic              store_bad, rsp_load;

  smrb_ram #(.WIDTH($bits(rec_t)), .DEPTH(DEPTH)) u_rec (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rd)
  );

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [ROW_W-1:0] r,
                                                  input logic [SLOT_W-1:0] sl);
    slot_addr = ADDR_W'(r) * ADDR_W'(SLOTS) + ADDR_W'(sl);
  endfunction

  always_comb begin
    out_free  = !rsp_valid || !rsp_stall;
    match     = sess_used[idx] && (sess_owner[idx] == op.owner_id);
    append    = ({1'b0, 8'(cur_cnt)} < {2'b0, max_pending}) && (cur_cnt < SLOTS_C);
    wslot     = append ? cur_cnt[SLOT_W-1:0] : best_slot;
    qual      = rd.seq > op.msg_seq;
    drop      = (op.func == FUNC_ACK) ? (rd.seq <= op.msg_seq)
                                      : (rd.expiry <= {1'b0, op.now_ms});
    mem_raddr = slot_addr(idx, s[SLOT_W-1:0]);
    mem_we    = (state == S_STWR) || (state == S_COMPACT && pend && !drop);
    if (state == S_STWR) begin
      mem_waddr         = slot_addr(idx, wslot);
      mem_wdata.seq     = op.msg_seq;
      mem_wdata.payload = op.payload_handle;
      mem_wdata.written = op.now_ms;
      mem_wdata.expiry  = {1'b0, op.now_ms} + {9'b0, ttl_ms};
    end else begin
      mem_waddr = slot_addr(idx, n[SLOT_W-1:0]);
      mem_wdata = rd;
    end
    store_bad = req.owner_id == '0 || req.msg_seq == '0 ||
                req.payload_handle == '0 || max_pending == '0 ||
                max_pending > PENDING_MAX || ttl_ms == '0;
    empty_rsp = '0;
    empty_rsp.last = 1'b1;
    empty_rsp.status = (req.func == FUNC_STORE && store_bad) ? ST_INVALID : ST_OK;
    msg_rsp = '0;
    msg_rsp.has_message = 1'b1;
    msg_rsp.out_seq     = held_seq;
    msg_rsp.out_payload = held_pay;
    last_rsp = msg_rsp;
    last_rsp.last = 1'b1;
    rsp_load = (state == S_DONE && out_free) ||
               (state == S_LIST && pend && qual && held_valid);
  end

  assign req_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      sess_used   <= '0;
      rsp_valid   <= 1'b0;
      max_pending <= PENDING_RST;
      ttl_ms      <= TTL_RST;
      pend        <= 1'b0;
      held_valid  <= 1'b0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == REG_MAX_PENDING) begin
          max_pending <= cfg_data[6:0];
        end else begin
          ttl_ms <= cfg_data;
        end
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            op         <= req;
            idx        <= '0;
            free_ok    <= 1'b0;
            removed    <= '0;
            s          <= '0;
            n          <= '0;
            k          <= '0;
            pend       <= 1'b0;
            dup        <= 1'b0;
            have_best  <= 1'b0;
            held_valid <= 1'b0;
            cap        <= (req.list_capacity > LIST_CAP_MAX) ? LIST_CAP_MAX
                                                             : req.list_capacity;
            res        <= empty_rsp;
            unique case (req.func)
              FUNC_STORE: state <= store_bad ? S_DONE : S_SCAN;
              FUNC_ACK:   state <= (req.msg_seq == '0) ? S_DONE : S_SCAN;
              FUNC_PRUNE: state <= S_PRROW;
              default:    state <= (req.list_capacity == '0) ? S_DONE : S_SCAN;
            endcase
          end
        end

        S_SCAN: begin
          if (match) begin
            cur_cnt <= sess_count[idx];
            unique case (op.func)
              FUNC_STORE: state <= S_STSCAN;
              FUNC_ACK:   state <= S_COMPACT;
              default:    state <= S_LIST;
            endcase
          end else begin
            if (!sess_used[idx] && !free_ok) begin
              free_row <= idx;
              free_ok  <= 1'b1;
            end
            if (idx == LAST_ROW) begin
              if (op.func == FUNC_STORE) begin
                if (free_ok || !sess_used[idx]) begin
                  idx     <= free_ok ? free_row : idx;
                  cur_cnt <= '0;
                  state   <= S_STSCAN;
                end else begin
                  res.status <= ST_NO_SESS;
                  state      <= S_DONE;
                end
              end else begin
                state <= S_DONE;
              end
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end

        S_STSCAN: begin
          if (s < cur_cnt) begin
            s    <= s + 1'b1;
            pend <= 1'b1;
          end else begin
            pend <= 1'b0;
          end
          if (pend) begin
            if (rd.seq == op.msg_seq) begin
              dup <= 1'b1;
            end
            if (!have_best || rd.written < best_w) begin
              have_best <= 1'b1;
              best_w    <= rd.written;
              best_slot <= SLOT_W'(s - 1'b1);
            end
          end
          if (s == cur_cnt && !pend) begin
            if (dup) begin
              res.status <= ST_DUP;
              state      <= S_DONE;
            end else begin
              state <= S_STWR;
            end
          end
        end

        S_STWR: begin
          sess_used[idx]  <= 1'b1;
          sess_owner[idx] <= op.owner_id;
          if (append) begin
            sess_count[idx] <= cur_cnt + 1'b1;
          end
          res.status <= ST_OK;
          state      <= S_DONE;
        end

        S_PRROW: begin
          if (sess_used[idx]) begin
            cur_cnt <= sess_count[idx];
            s       <= '0;
            n       <= '0;
            pend    <= 1'b0;
            state   <= S_COMPACT;
          end else if (idx == LAST_ROW) begin
            res.freed_count <= removed;
            state           <= S_DONE;
          end else begin
            idx <= idx + 1'b1;
          end
        end

        S_COMPACT: begin
          if (s < cur_cnt) begin
            s    <= s + 1'b1;
            pend <= 1'b1;
          end else begin
            pend <= 1'b0;
          end
          if (pend) begin
            if (drop) begin
              if (removed != REMOVED_SAT) begin
                removed <= removed + 1'b1;
              end
            end else begin
              n <= n + 1'b1;
            end
          end
          if (s == cur_cnt && !pend) begin
            sess_count[idx] <= n;
            if (n == '0) begin
              sess_used[idx]  <= 1'b0;
              sess_owner[idx] <= '0;
            end
            if (op.func == FUNC_ACK || idx == LAST_ROW) begin
              res.freed_count <= removed;
              state           <= S_DONE;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_PRROW;
            end
          end
        end

        S_LIST: begin
          if (pend) begin
            pend <= 1'b0;
            if (qual) begin
              if (held_valid) begin
                rsp <= msg_rsp;
              end
              held_valid <= 1'b1;
              held_seq   <= rd.seq;
              held_pay   <= rd.payload;
              k          <= k + 1'b1;
            end
          end else if (s >= cur_cnt || 7'(k) >= cap) begin
            if (held_valid) begin
              res <= last_rsp;
            end
            state <= S_DONE;
          end else if (out_free) begin
            s    <= s + 1'b1;
            pend <= 1'b1;
          end
        end

        S_DONE: begin
          if (out_free) begin
            rsp   <= res;
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> sv/smrb_checker.sv
// Port-level checks for the session message retention buffer, bound to the top level.
// Depends on smrb_pkg and session_message_retention_buffer_core.
`timescale 1ns / 1ps
`default_nettype none
module smrb_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           req_valid,
  input wire logic           req_stall,
  input wire logic           rsp_valid,
  input wire logic           rsp_stall,
  input wire smrb_pkg::rsp_t rsp
);
  import smrb_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("rsp changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("new transaction taken while busy");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.has_message |-> rsp.last)
    else $error("non-message result not last");

  a_msg_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.has_message |-> rsp.status == ST_OK && rsp.freed_count == '0)
    else $error("message result with status or count");

endmodule

bind session_message_retention_buffer_core smrb_checker u_smrb_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
`default_nettype wire

>>> dv/session_message_retention_buffer_core_test.sv
// Testbench for session_message_retention_buffer_core: directed and random store, ack,
// prune and list transactions checked against a scoreboard that tracks every session row.
// Depends on smrb_pkg and the RTL of the block.
`timescale 1ns / 1ps
import smrb_pkg::*;

class retention_scoreboard;
  logic [6:0]  max_pending = PENDING_RST;
  logic [31:0] ttl_ms = TTL_RST;
  bit          row_used[16];
  logic [31:0] row_owner[16];
  int          row_count[16];
  bit          rec_valid[16][64];
  logic [31:0] rec_seq[16][64];
  logic [31:0] rec_payload[16][64];
  logic [39:0] rec_written[16][64];
  logic [40:0] rec_expiry[16][64];
  rsp_t        pending_rsp[$];
  int          errors = 0;

  function void set_registers(logic [6:0] mp, logic [31:0] ttl);
    max_pending = mp;
    ttl_ms = ttl;
  endfunction

  function int find_row(logic [31:0] own);
    for (int r = 0; r < 16; r++)
      if (row_used[r] && row_owner[r] == own) return r;
    return -1;
  endfunction

  function void clear_record(int r, int s);
    rec_valid[r][s] = 0;
    rec_seq[r][s] = '0;
    rec_payload[r][s] = '0;
    rec_written[r][s] = '0;
    rec_expiry[r][s] = '0;
  endfunction

  function void compact_row(int r);
    int n;
    n = 0;
    for (int s = 0; s < 64; s++) begin
      if (!rec_valid[r][s]) continue;
      if (n != s) begin
        rec_valid[r][n] = 1;
        rec_seq[r][n] = rec_seq[r][s];
        rec_payload[r][n] = rec_payload[r][s];
        rec_written[r][n] = rec_written[r][s];
        rec_expiry[r][n] = rec_expiry[r][s];
        clear_record(r, s);
      end
      n++;
    end
    row_count[r] = n;
    if (n == 0) begin
      row_used[r] = 0;
      row_owner[r] = '0;
    end
  endfunction

  function logic [2:0] store_message(req_t t);
    int r;
    int slot;
    if (t.owner_id == 0 || t.msg_seq == 0 || t.payload_handle == 0 || max_pending == 0 ||
        max_pending > PENDING_MAX || ttl_ms == 0)
      return ST_INVALID;
    r = find_row(t.owner_id);
    if (r < 0) begin
      for (int i = 0; i < 16; i++)
        if (!row_used[i]) begin
          r = i;
          break;
        end
      if (r < 0) return ST_NO_SESS;
      row_used[r] = 1;
      row_owner[r] = t.owner_id;
      row_count[r] = 0;
    end
    for (int s = 0; s < 64; s++)
      if (rec_valid[r][s] && rec_seq[r][s] == t.msg_seq) return ST_DUP;
    slot = -1;
    if (row_count[r] < max_pending)
      for (int s = 0; s < 64; s++)
        if (!rec_valid[r][s]) begin
          slot = s;
          break;
        end
    if (slot < 0) begin
      for (int s = 0; s < 64; s++)
        if (rec_valid[r][s] && (slot < 0 || rec_written[r][s] < rec_written[r][slot]))
          slot = s;
      if (slot < 0) return ST_NO_SLOT;
    end
    rec_valid[r][slot] = 1;
    rec_seq[r][slot] = t.msg_seq;
    rec_payload[r][slot] = t.payload_handle;
    rec_written[r][slot] = t.now_ms;
    rec_expiry[r][slot] = {1'b0, t.now_ms} + {9'd0, ttl_ms};
    compact_row(r);
    return ST_OK;
  endfunction

  function void note_request(req_t t);
    rsp_t o;
    int r;
    int n;
    int cap;
    o = '0;
    o.last = 1;
    n = 0;
    case (t.func)
      FUNC_STORE: begin
        o.status = store_message(t);
        pending_rsp.push_back(o);
      end
      FUNC_ACK, FUNC_PRUNE: begin
        for (r = 0; r < 16; r++) begin
          if (!row_used[r]) continue;
          if (t.func == FUNC_ACK && (row_owner[r] != t.owner_id || t.msg_seq == 0)) continue;
          for (int s = 0; s < 64; s++)
            if (rec_valid[r][s] && ((t.func == FUNC_ACK) ? rec_seq[r][s] <= t.msg_seq :
                (rec_expiry[r][s] != 0 && rec_expiry[r][s] <= {1'b0, t.now_ms}))) begin
              clear_record(r, s);
              n++;
            end
          compact_row(r);
        end
        o.freed_count = (n > 2047) ? REMOVED_SAT : n[10:0];
        pending_rsp.push_back(o);
      end
      default: begin
        cap = int'((t.list_capacity > LIST_CAP_MAX) ? LIST_CAP_MAX : t.list_capacity);
        r = find_row(t.owner_id);
        if (r >= 0)
          for (int s = 0; s < 64 && n < cap; s++) begin
            if (!rec_valid[r][s] || rec_seq[r][s] <= t.msg_seq) continue;
            o = '0;
            o.has_message = 1;
            o.out_seq = rec_seq[r][s];
            o.out_payload = rec_payload[r][s];
            pending_rsp.push_back(o);
            n++;
          end
        if (n == 0) pending_rsp.push_back(o);
        else pending_rsp[$].last = 1;
      end
    endcase
  endfunction

  function void check_response(rsp_t a);
    rsp_t e;
    if (pending_rsp.size() == 0) begin
      $display("%0t: unexpected transaction, actual %p", $time, a);
      errors++;
      return;
    end
    e = pending_rsp.pop_front();
    if (a.status !== e.status || a.freed_count !== e.freed_count ||
        a.has_message !== e.has_message || a.out_seq !== e.out_seq ||
        a.out_payload !== e.out_payload || a.last !== e.last) begin
      $display("%0t: mismatch, expected %p, actual %p", $time, e, a);
      errors++;
    end
  endfunction
endclass

module session_message_retention_buffer_core_test;
  logic        clk = 0;
  logic        rst = 1;
  logic        req_valid = 0;
  logic        req_stall;
  req_t        req = '0;
  logic        rsp_valid;
  logic        rsp_stall = 0;
  rsp_t        rsp;
  logic        cfg_write = 0;
  logic        cfg_index = REG_MAX_PENDING;
  logic [31:0] cfg_data = '0;

  retention_scoreboard sb = new();
  int send_idle = 0;
  int recv_idle = 0;
  logic [39:0] clock_ms = 40'd1000;
  logic [31:0] owner_pool[20];

  session_message_retention_buffer_core DUT (.*);

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rsp_valid && !rsp_stall) sb.check_response(rsp);
    rsp_stall <= ($urandom_range(99) < recv_idle);
  end

  initial begin
    #50ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic send(req_t t);
    while ($urandom_range(99) < send_idle) begin
      req_valid <= 0;
      @(posedge clk);
    end
    req_valid <= 1;
    req <= t;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sb.note_request(t);
  endtask

  task automatic drain();
    req_valid <= 0;
    @(posedge clk);
    while (sb.pending_rsp.size() != 0) @(posedge clk);
  endtask

  task automatic set_registers(logic [6:0] mp, logic [31:0] ttl);
    drain();
    repeat (200) @(posedge clk);
    cfg_write <= 1;
    cfg_index <= REG_MAX_PENDING;
    cfg_data <= {25'd0, mp};
    @(posedge clk);
    cfg_index <= REG_TTL_MS;
    cfg_data <= ttl;
    @(posedge clk);
    cfg_write <= 0;
    sb.set_registers(mp, ttl);
  endtask

  function automatic req_t make_req(logic [1:0] f, logic [31:0] own, logic [31:0] sq,
                                    logic [31:0] pay, logic [39:0] now, logic [6:0] cap);
    req_t t;
    t.func = f;
    t.owner_id = own;
    t.msg_seq = sq;
    t.payload_handle = pay;
    t.now_ms = now;
    t.list_capacity = cap;
    return t;
  endfunction

  function automatic req_t random_req();
    req_t t;
    int k;
    k = $urandom_range(99);
    t.func = (k < 50) ? FUNC_STORE : (k < 65) ? FUNC_ACK : (k < 75) ? FUNC_PRUNE : FUNC_LIST;
    k = $urandom_range(99);
    t.owner_id = (k < 2) ? 32'd0 : (k < 7) ? $urandom : owner_pool[$urandom_range(19)];
    k = $urandom_range(99);
    t.msg_seq = (k < 3) ? 32'd0 : (k < 8) ? $urandom : $urandom_range(1, 40);
    t.payload_handle = ($urandom_range(99) < 3) ? 32'd0 : $urandom;
    clock_ms = clock_ms + $urandom_range(0, 50);
    t.now_ms = ($urandom_range(99) < 3) ? 40'({$urandom, $urandom}) : clock_ms;
    t.list_capacity = ($urandom_range(1)) ? 7'($urandom_range(0, 8))
                                          : 7'($urandom_range(0, 127));
    return t;
  endfunction

  task automatic random_phase(int n, int s_idle, int r_idle, logic [6:0] mp, logic [31:0] ttl);
    set_registers(mp, ttl);
    send_idle = s_idle;
    recv_idle = r_idle;
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) drain();
      send(random_req());
    end
  endtask

  initial begin
    for (int i = 0; i < 20; i++) owner_pool[i] = (i == 19) ? 32'hFFFF_FFFF : 32'h0101_0101 * (i + 1);
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send(make_req(FUNC_STORE, 32'd0, 32'd5, 32'd7, 40'd10, 7'd0));
    send(make_req(FUNC_STORE, 32'd9, 32'd0, 32'd7, 40'd10, 7'd0));
    send(make_req(FUNC_STORE, 32'd9, 32'd5, 32'd0, 40'd10, 7'd0));
    send(make_req(FUNC_STORE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  40'hFF_FFFF_FFFF, 7'h7F));
    send(make_req(FUNC_STORE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1234, 40'd20, 7'd0));
    for (int i = 1; i < 16; i++)
      send(make_req(FUNC_STORE, i, i, 32'hA000 + i, 40'd100 + i, 7'd0));
    send(make_req(FUNC_STORE, 32'd77, 32'd1, 32'd1, 40'd200, 7'd0));
    send(make_req(FUNC_LIST, 32'hFFFF_FFFF, 32'd0, 32'd0, 40'd0, 7'h7F));
    send(make_req(FUNC_LIST, 32'd3, 32'd0, 32'd0, 40'd0, 7'd0));
    send(make_req(FUNC_LIST, 32'd77, 32'd0, 32'd0, 40'd0, 7'd5));
    send(make_req(FUNC_ACK, 32'd3, 32'd3, 32'd0, 40'd0, 7'd0));
    send(make_req(FUNC_PRUNE, 32'd0, 32'd0, 32'd0, 40'd40000, 7'd0));

    random_phase(150, 18, 85, 7'd4, 32'd500);
    random_phase(10, 18, 85, 7'd0, 32'd500);
    random_phase(10, 18, 85, 7'd100, 32'd500);
    random_phase(10, 18, 85, 7'd3, 32'd0);
    random_phase(130, 85, 18, PENDING_MAX, 32'hFFFF_FFFF);
    random_phase(130, 0, 0, 7'd1, 32'd1);

    drain();
    repeat (2000) @(posedge clk);
    if (sb.errors == 0 && sb.pending_rsp.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
